>>> hw/rtl/rhsv_pkg.sv
`default_nettype none

package rhsv_pkg;

    // Channel width and number of hue and saturation fraction bits.
    localparam int CHAN_W = 8;
    localparam int FRAC_W = 8;

    // Both quotients lie on 0..2^FRAC_W, so they need FRAC_W+1 bits, one per divider step.
    localparam int DIV_STEPS = FRAC_W + 1;

    // Result field widths.
    localparam int HUE_W = 11;
    localparam int SAT_W = 9;

    // Sector codes: which channel is the minimum.
    localparam logic [1:0] SEC_RED   = 2'd0;
    localparam logic [1:0] SEC_GREEN = 2'd1;
    localparam logic [1:0] SEC_BLUE  = 2'd2;

    // Per-pixel data that rides along beside the dividers.
    typedef struct packed {
        logic [1:0]        sector;
        logic              neg;
        logic              undef;
        logic [CHAN_W-1:0] hi;
    } t_side;

endpackage

`default_nettype wire

>>> hw/rtl/rgb_to_hsv_converter.sv
`default_nettype none

// RGB to HSV converter. One pixel request enters per clock unless stalled, and its
// result leaves in order (CHANNEL+FRACTION set to 8: one front stage that finds the
// minimum, the maximum and the sector, nine divider stages that each settle one
// quotient bit for both hue and saturation, and one output stage that applies the
// sector base and the sign). Sustained throughput is one pixel per clock while the
// output is not stalled. Hue runs on 0..1536 (0..6 with 8 fraction bits), saturation
// on 0..256 (256 is 1.0) and brightness is the largest channel. When all three
// channels are equal the hue undefined flag is set and hue and saturation read as
// zero. Each stage holds its request while the stage after it is full and stalled,
// so bubbles squeeze out and a stall at the output loses and repeats nothing.
module rgb_to_hsv_converter (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_stall,
    input  wire logic [rhsv_pkg::CHAN_W-1:0]  i_red,
    input  wire logic [rhsv_pkg::CHAN_W-1:0]  i_green,
    input  wire logic [rhsv_pkg::CHAN_W-1:0]  i_blue,
    output logic                              o_valid,
    input  wire logic                         i_stall,
    output logic      [rhsv_pkg::HUE_W-1:0]   o_hue,
    output logic      [rhsv_pkg::SAT_W-1:0]   o_saturation,
    output logic      [rhsv_pkg::CHAN_W-1:0]  o_brightness,
    output logic                              o_hue_undefined
);
    import rhsv_pkg::*;

    // Stage 0 is the front register, stages 1..DIV_STEPS are the divider steps
    // and the last stage is the output register.
    localparam int NUM_STAGES = DIV_STEPS + 2;
    localparam int LAST       = NUM_STAGES - 1;

    logic [NUM_STAGES-1:0] r_vld;
    logic [NUM_STAGES-1:0] w_rdy;

    // A stage may load when it is empty or when its own request moves on.
    always_comb begin
        w_rdy[LAST] = !r_vld[LAST] || !i_stall;
        for (int k = LAST - 1; k >= 0; k--) begin
            w_rdy[k] = !r_vld[k] || w_rdy[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_rdy[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < NUM_STAGES; k++) begin
                if (w_rdy[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign o_stall = !w_rdy[0];
    assign o_valid = r_vld[LAST];

    // Front stage: minimum, maximum, sector choice and the magnitude of the difference.
    logic [CHAN_W-1:0] n_lo;
    logic [CHAN_W-1:0] n_hi;
    logic [CHAN_W-1:0] n_pos;
    logic [CHAN_W-1:0] n_negv;
    logic [CHAN_W-1:0] n_fabs;
    logic [CHAN_W-1:0] n_span;
    t_side             n_side;

    always_comb begin
        n_lo = (i_red < i_green) ? i_red : i_green;
        n_lo = (n_lo < i_blue) ? n_lo : i_blue;
        n_hi = (i_red > i_green) ? i_red : i_green;
        n_hi = (n_hi > i_blue) ? n_hi : i_blue;

        // Ties for the minimum go to red first, then green.
        if (i_red == n_lo) begin
            n_side.sector = SEC_RED;
            n_pos         = i_green;
            n_negv        = i_blue;
        end else if (i_green == n_lo) begin
            n_side.sector = SEC_GREEN;
            n_pos         = i_blue;
            n_negv        = i_red;
        end else begin
            n_side.sector = SEC_BLUE;
            n_pos         = i_red;
            n_negv        = i_green;
        end

        // The quotient is taken on the magnitude; the sign is applied at the end.
        n_side.neg   = (n_pos < n_negv);
        n_fabs       = n_side.neg ? (n_negv - n_pos) : (n_pos - n_negv);
        n_span       = n_hi - n_lo;
        n_side.undef = (n_hi == n_lo);
        n_side.hi    = n_hi;
    end

    logic [CHAN_W-1:0] r_fabs;
    logic [CHAN_W-1:0] r_span;
    t_side             r_side [DIV_STEPS+1];

    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r_fabs    <= n_fabs;
            r_span    <= n_span;
            r_side[0] <= n_side;
        end
        for (int k = 1; k <= DIV_STEPS; k++) begin
            if (w_rdy[k]) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    // Hue divides |f| by the span, saturation divides the span by the maximum. When
    // all channels are equal the divisor may be zero; those quotients are discarded.
    logic [DIV_STEPS-1:0] w_hue_quo;
    logic [DIV_STEPS-1:0] w_sat_quo;

    rhsv_div u_hue_div (
        .i_clk (i_clk),
        .i_en  (w_rdy[DIV_STEPS:1]),
        .i_num (r_fabs),
        .i_den (r_span),
        .o_quo (w_hue_quo)
    );

    rhsv_div u_sat_div (
        .i_clk (i_clk),
        .i_en  (w_rdy[DIV_STEPS:1]),
        .i_num (r_span),
        .i_den (r_side[0].hi),
        .o_quo (w_sat_quo)
    );

    // Output stage: sector base times one, minus or plus the quotient.
    logic [HUE_W-1:0] n_base;
    logic [HUE_W-1:0] n_mag;
    logic [HUE_W-1:0] n_hue;
    logic [SAT_W-1:0] n_sat;
    t_side            w_tail;

    assign w_tail = r_side[DIV_STEPS];

    always_comb begin
        unique case (w_tail.sector)
            SEC_RED:   n_base = HUE_W'(3) << FRAC_W;
            SEC_GREEN: n_base = HUE_W'(5) << FRAC_W;
            SEC_BLUE:  n_base = HUE_W'(1) << FRAC_W;
            default:   n_base = '0;
        endcase
        n_mag = HUE_W'(w_hue_quo);
        if (w_tail.undef) begin
            n_hue = '0;
            n_sat = '0;
        end else begin
            n_hue = w_tail.neg ? (n_base + n_mag) : (n_base - n_mag);
            n_sat = SAT_W'(w_sat_quo);
        end
    end

    logic [HUE_W-1:0]  r_hue;
    logic [SAT_W-1:0]  r_sat;
    logic [CHAN_W-1:0] r_bri;
    logic              r_und;

    always_ff @(posedge i_clk) begin
        if (w_rdy[LAST]) begin
            r_hue <= n_hue;
            r_sat <= n_sat;
            r_bri <= w_tail.hi;
            r_und <= w_tail.undef;
        end
    end

    assign o_hue           = r_hue;
    assign o_saturation    = r_sat;
    assign o_brightness    = r_bri;
    assign o_hue_undefined = r_und;

endmodule

`default_nettype wire

>>> hw/rtl/rhsv_div.sv
`default_nettype none

module rhsv_div (
    input  wire logic                            i_clk,
    input  wire logic [rhsv_pkg::DIV_STEPS-1:0]  i_en,
    input  wire logic [rhsv_pkg::CHAN_W-1:0]     i_num,
    input  wire logic [rhsv_pkg::CHAN_W-1:0]     i_den,
    output logic      [rhsv_pkg::DIV_STEPS-1:0]  o_quo
);
    import rhsv_pkg::*;

    // Pipelined restoring divider for floor(num * 2^FRAC_W / den) with num <= den.
    // Each step settles one quotient bit, most significant first.
    logic [CHAN_W-1:0]    r_rem [DIV_STEPS];
    logic [CHAN_W-1:0]    r_den [DIV_STEPS];
    logic [DIV_STEPS-1:0] r_quo [DIV_STEPS];

    logic [CHAN_W-1:0]    n_rem [DIV_STEPS];
    logic [CHAN_W-1:0]    n_den [DIV_STEPS];
    logic [DIV_STEPS-1:0] n_quo [DIV_STEPS];

    always_comb begin
        logic [CHAN_W:0]      trial;
        logic [CHAN_W:0]      den_x;
        logic [DIV_STEPS-1:0] quo_in;
        logic                 ge;
        for (int j = 0; j < DIV_STEPS; j++) begin
            if (j == 0) begin
                // The top bit is set only when num equals den.
                trial    = {1'b0, i_num};
                den_x    = {1'b0, i_den};
                quo_in   = '0;
                n_den[j] = i_den;
            end else begin
                trial    = {r_rem[j-1], 1'b0};
                den_x    = {1'b0, r_den[j-1]};
                quo_in   = r_quo[j-1];
                n_den[j] = r_den[j-1];
            end
            ge       = (trial >= den_x);
            n_rem[j] = ge ? CHAN_W'(trial - den_x) : CHAN_W'(trial);
            n_quo[j] = {quo_in[DIV_STEPS-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < DIV_STEPS; j++) begin
            if (i_en[j]) begin
                r_rem[j] <= n_rem[j];
                r_den[j] <= n_den[j];
                r_quo[j] <= n_quo[j];
            end
        end
    end

    assign o_quo = r_quo[DIV_STEPS-1];

endmodule

`default_nettype wire

>>> sim/rgb_to_hsv_converter_tb.sv
`default_nettype none

module rgb_to_hsv_converter_tb;

    import rhsv_pkg::*;

    // One pixel request as it enters the converter.
    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } t_pixel;

    // One HSV result as it leaves the converter.
    typedef struct packed {
        logic [HUE_W-1:0]  hue;
        logic [SAT_W-1:0]  sat;
        logic [CHAN_W-1:0] bright;
        logic              undef;
    } t_hsv;

    // Traffic phases. The first two trade idle rates between the two sides,
    // and the last runs both sides flat out.
    localparam int PH_SEND_SLOW = 0;
    localparam int PH_RECV_SLOW = 1;
    localparam int PH_FULL_RATE = 2;

    localparam int RANDOM_PIXELS  = 1500;
    localparam int PHASE_LEN      = 500;
    // The long receiver hold-off starts once this many requests went in,
    // which lands it in the full rate phase where the sender never pauses.
    localparam int HOLD_AT        = 1100;
    localparam int HOLD_CYCLES    = 80;
    localparam int DRAIN_CYCLES   = 30;
    localparam int WATCHDOG_LIMIT = 2000;

    logic                i_clk   = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic                i_stall = 1'b0;
    logic [CHAN_W-1:0]   i_red   = '0;
    logic [CHAN_W-1:0]   i_green = '0;
    logic [CHAN_W-1:0]   i_blue  = '0;
    logic                o_stall;
    logic                o_valid;
    logic [HUE_W-1:0]    o_hue;
    logic [SAT_W-1:0]    o_saturation;
    logic [CHAN_W-1:0]   o_brightness;
    logic                o_hue_undefined;

    t_pixel pixel_queue[$];     // requests still to be offered
    t_hsv   hsv_expected[$];    // predicted results, oldest first
    int     pixels_in   = 0;    // requests accepted by the converter
    int     errors      = 0;
    int     quiet_count = 0;    // cycles in a row with no handshake
    int     hold_left   = 0;    // remaining cycles of the long hold-off
    bit     hold_done   = 1'b0;
    logic   req_taken   = 1'b0; // the request on the bus went in at the last edge

    rgb_to_hsv_converter uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_red           (i_red),
        .i_green         (i_green),
        .i_blue          (i_blue),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_hue           (o_hue),
        .o_saturation    (o_saturation),
        .o_brightness    (o_brightness),
        .o_hue_undefined (o_hue_undefined)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Fixed point HSV of one pixel. The sector comes from the first channel
    // equal to the minimum, scanning red, green, blue. The hue quotient is
    // truncated on its magnitude and the sign is applied afterwards, so a
    // negative offset rounds toward the sector base rather than away from it.
    function automatic t_hsv rgb_to_hsv_model(input t_pixel px);
        int   r;
        int   g;
        int   b;
        int   lo;
        int   hi;
        int   span;
        int   up;
        int   down;
        int   base;
        int   mag;
        int   hue;
        int   sat;
        t_hsv res;
        r  = px.red;
        g  = px.green;
        b  = px.blue;
        lo = (r < g) ? r : g;
        lo = (lo < b) ? lo : b;
        hi = (r > g) ? r : g;
        hi = (hi > b) ? hi : b;
        res.bright = hi[CHAN_W-1:0];
        if (hi == lo) begin
            // Gray pixel, black included: no division, the hue is meaningless.
            res.hue   = '0;
            res.sat   = '0;
            res.undef = 1'b1;
            return res;
        end
        if (r == lo) begin
            base = 3; up = g; down = b;
        end else if (g == lo) begin
            base = 5; up = b; down = r;
        end else begin
            base = 1; up = r; down = g;
        end
        span = hi - lo;
        if (up >= down) begin
            mag = ((up - down) << FRAC_W) / span;
            hue = (base << FRAC_W) - mag;
        end else begin
            mag = ((down - up) << FRAC_W) / span;
            hue = (base << FRAC_W) + mag;
        end
        sat       = (span << FRAC_W) / hi;
        res.hue   = hue[HUE_W-1:0];
        res.sat   = sat[SAT_W-1:0];
        res.undef = 1'b0;
        return res;
    endfunction

    function automatic t_pixel make_pixel(input int r, input int g, input int b);
        t_pixel px;
        px.red   = r[CHAN_W-1:0];
        px.green = g[CHAN_W-1:0];
        px.blue  = b[CHAN_W-1:0];
        return px;
    endfunction

    // Random pixel with a bias toward the interesting regions: gray pixels,
    // ties for the minimum and narrow spans where the divider has few bits to
    // work with. Most pixels are still uniform so every input bit toggles.
    function automatic t_pixel random_pixel();
        int     kind;
        int     v;
        int     w;
        t_pixel px;
        kind = $urandom_range(0, 9);
        v    = $urandom_range(0, 255);
        w    = $urandom_range(0, 255);
        case (kind)
            0: begin
                px = make_pixel(v, v, v);
            end
            1: begin
                case ($urandom_range(0, 2))
                    0:       px = make_pixel(v, v, w);
                    1:       px = make_pixel(v, w, v);
                    default: px = make_pixel(w, v, v);
                endcase
            end
            2: begin
                // Green and blue within three codes of red, wrapping modulo 256.
                px = make_pixel(v, (v + $urandom_range(0, 3)) % 256,
                                (v + 256 - $urandom_range(0, 3)) % 256);
            end
            default: begin
                px = make_pixel($urandom_range(0, 255), v, w);
            end
        endcase
        return px;
    endfunction

    task automatic check_field(input string name, input int exp_val, input int got_val);
        if (exp_val != got_val) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, name, exp_val, got_val);
            errors++;
        end
    endtask

    // Which traffic phase the run is in, from the number of accepted requests.
    function automatic int traffic_phase();
        if (pixels_in < PHASE_LEN) begin
            return PH_SEND_SLOW;
        end else if (pixels_in < 2 * PHASE_LEN) begin
            return PH_RECV_SLOW;
        end
        return PH_FULL_RATE;
    endfunction

    // Sender: a new request is picked only when the bus is free or the request
    // on it went in at the last rising edge, so a stalled request stays put.
    // The choice to pause never looks at o_stall.
    always @(negedge i_clk) begin
        int     idle_pct;
        t_pixel px;
        idle_pct = 0;
        if (traffic_phase() == PH_SEND_SLOW) begin
            idle_pct = 31;
        end else if (traffic_phase() == PH_RECV_SLOW) begin
            idle_pct = 60;
        end
        if (i_rst_n && (!i_valid || req_taken)) begin
            if (pixel_queue.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
                px = pixel_queue.pop_front();
                i_valid <= 1'b1;
                i_red   <= px.red;
                i_green <= px.green;
                i_blue  <= px.blue;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls by phase, plus one long hold-off while the sender
    // keeps offering, long enough to fill every pipeline stage and push the
    // back-pressure all the way to o_stall.
    always @(negedge i_clk) begin
        int stall_pct;
        stall_pct = 0;
        if (traffic_phase() == PH_SEND_SLOW) begin
            stall_pct = 60;
        end else if (traffic_phase() == PH_RECV_SLOW) begin
            stall_pct = 31;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else if (!hold_done && pixels_in >= HOLD_AT) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // Monitor and scoreboard. The result side is checked before the request
    // side is recorded: a result leaving at an edge can never belong to the
    // request entering at that same edge.
    always @(posedge i_clk) begin
        t_hsv   exp_hsv;
        t_pixel px;
        req_taken <= i_rst_n && i_valid && !o_stall;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (hsv_expected.size() == 0) begin
                    $display("%0t: result with none expected, actual hue %0d sat %0d v %0d u %0d",
                             $time, o_hue, o_saturation, o_brightness, o_hue_undefined);
                    errors++;
                end else begin
                    exp_hsv = hsv_expected.pop_front();
                    check_field("hue", exp_hsv.hue, o_hue);
                    check_field("saturation", exp_hsv.sat, o_saturation);
                    check_field("brightness", exp_hsv.bright, o_brightness);
                    check_field("hue_undefined", exp_hsv.undef, o_hue_undefined);
                end
            end
            if (i_valid && !o_stall) begin
                px.red   = i_red;
                px.green = i_green;
                px.blue  = i_blue;
                hsv_expected.push_back(rgb_to_hsv_model(px));
                pixels_in++;
            end
        end
    end

    // Watchdog: too long without any handshake on either side means a hang.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_count <= 0;
        end else if (quiet_count >= WATCHDOG_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("rgb_to_hsv_converter_tb: done, errors");
            $finish;
        end else begin
            quiet_count <= quiet_count + 1;
        end
    end

    initial begin
        int total;
        // Directed pixels: black and white, the primaries and secondaries,
        // ties for the minimum in every pairing, one-code spans, gray levels,
        // and both signs of the hue offset in each sector.
        pixel_queue.push_back(make_pixel(0, 0, 0));
        pixel_queue.push_back(make_pixel(255, 255, 255));
        pixel_queue.push_back(make_pixel(128, 128, 128));
        pixel_queue.push_back(make_pixel(1, 1, 1));
        pixel_queue.push_back(make_pixel(255, 0, 0));
        pixel_queue.push_back(make_pixel(0, 255, 0));
        pixel_queue.push_back(make_pixel(0, 0, 255));
        pixel_queue.push_back(make_pixel(255, 255, 0));
        pixel_queue.push_back(make_pixel(0, 255, 255));
        pixel_queue.push_back(make_pixel(255, 0, 255));
        pixel_queue.push_back(make_pixel(10, 10, 200));
        pixel_queue.push_back(make_pixel(200, 10, 10));
        pixel_queue.push_back(make_pixel(10, 200, 10));
        pixel_queue.push_back(make_pixel(1, 0, 0));
        pixel_queue.push_back(make_pixel(0, 1, 0));
        pixel_queue.push_back(make_pixel(0, 0, 1));
        pixel_queue.push_back(make_pixel(254, 255, 255));
        pixel_queue.push_back(make_pixel(255, 254, 255));
        pixel_queue.push_back(make_pixel(0, 10, 255));
        pixel_queue.push_back(make_pixel(0, 255, 10));
        pixel_queue.push_back(make_pixel(255, 0, 7));
        pixel_queue.push_back(make_pixel(7, 0, 255));
        pixel_queue.push_back(make_pixel(255, 7, 0));
        pixel_queue.push_back(make_pixel(7, 255, 0));
        pixel_queue.push_back(make_pixel(170, 85, 1));
        for (int k = 0; k < RANDOM_PIXELS; k++) begin
            pixel_queue.push_back(random_pixel());
        end
        total = pixel_queue.size();

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Every request in, every result out, then a few more cycles so a
        // stray extra result would still be caught by the monitor.
        wait (pixels_in == total && hsv_expected.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("rgb_to_hsv_converter_tb: done, clean");
        end else begin
            $display("rgb_to_hsv_converter_tb: done, errors");
        end
        $finish;
    end

endmodule

`default_nettype wire

>>> sim.f
hw/rtl/rhsv_pkg.sv
hw/rtl/rhsv_div.sv
hw/rtl/rgb_to_hsv_converter.sv
sim/rgb_to_hsv_converter_tb.sv
